[rtl/rcrs_pkg.sv]
// shared types and constants of the remainder carrying rate scaler
package rcrs_pkg;

  // operation codes
  localparam logic [1:0] FUNC_SCALE = 2'd0;
  localparam logic [1:0] FUNC_SLEW  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // kept sign codes
  localparam logic signed [1:0] SGN_ZERO = 2'sb00;
  localparam logic signed [1:0] SGN_POS  = 2'sb01;
  localparam logic signed [1:0] SGN_NEG  = 2'sb11;

  // field widths
  localparam int PLAYER_W  = 3;
  localparam int CHANNEL_W = 4;
  localparam int AMOUNT_W  = 32;
  localparam int TICK_W    = 16;
  localparam int DEN_W     = 16;
  localparam int REM_W     = DEN_W + 1;
  localparam int NUM_W     = 48;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int PLAYER_SLOTS = 2 ** PLAYER_W;

  // slew constants: small difference, gain of four, divide by eight as a shift
  localparam logic [AMOUNT_W-1:0] SLEW_SMALL    = 32'd8;
  localparam int                  SLEW_GAIN_SH  = 2;
  localparam int                  SLEW_DIV_SH   = 3;
  // one 29th as ceil(2^36 / 29) and a shift by 36, exact for magnitudes up to 2^31
  localparam logic [AMOUNT_W-1:0] SLEW_RECIP    = 32'd2369637129;
  localparam int                  SLEW_RECIP_SH = 36;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // classified item
  typedef struct packed {
    logic [1:0]                 func;
    logic [PLAYER_W-1:0]        player_index;
    logic [CHANNEL_W-1:0]       channel_index;
    logic signed [AMOUNT_W-1:0] amount;
    logic [TICK_W-1:0]          tick_count;
    logic [DEN_W-1:0]           divisor_value;
    logic                       chan_ok;
    logic                       entry_ok;
    logic                       div_zero;
    logic                       small_diff;
    logic [AMOUNT_W-1:0]        mag;
  } job_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

  // one store entry
  typedef struct packed {
    logic signed [REM_W-1:0] rem;
    logic signed [1:0]       sgn;
  } entry_t;

endpackage

[rtl/rcrs_in_if.sv]
// input channel interface
interface rcrs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [2:0]         player_index;
  logic [3:0]         channel_index;
  logic signed [31:0] amount;
  logic [15:0]        tick_count;
  logic [15:0]        divisor_value;

  modport source (output valid, func, player_index, channel_index, amount, tick_count,
                  divisor_value, input ready);
  modport sink (input valid, func, player_index, channel_index, amount, tick_count,
                divisor_value, output ready);
endinterface

[rtl/rcrs_out_if.sv]
// result channel interface
interface rcrs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] scaled_out;

  modport source (output valid, scaled_out, input ready);
  modport sink (input valid, scaled_out, output ready);
endinterface

[rtl/remainder_carry_rate_scaler_top.sv]
// Remainder carrying rate scaler: per player and channel, a scale transaction returns
// (amount * tick_count + kept remainder) / divisor_value truncated toward zero and
// saturated to 32 bits, keeping the new remainder; a slew transaction steps toward a
// target by about one 29th of the difference scaled by 4/8 per tick; a clear transaction
// zeroes an entry. Every transaction gives exactly one result. A front stage classifies
// transactions into a two-entry queue, and a back sequencer works on one at a time.
// A scale goes through a 48-step radix-2 divider, which sets the pace. A slew takes its
// step by a reciprocal multiply and divides by 8 with a shift; a clear or a trivial
// answer goes straight to the result. The back end can take the next transaction in
// the same cycle in which it presents a result. The remainder store is a memory of
// PLAYERS (at most 8) times CHANNELS entries with a valid bit per entry, cleared at
// once by reset, so no clearing pass follows reset.
module remainder_carry_rate_scaler_top import rcrs_pkg::*; #(
  parameter int PLAYERS  = 8,
  parameter int CHANNELS = 9
) (
  input  logic       clk,
  input  logic       rst_n,
  rcrs_in_if.sink    in_ch,
  rcrs_out_if.source out_ch
);

  logic     q_push;
  logic     q_pop;
  job_t     q_data;
  job_t     q_head;
  q_stat_t  q_stat;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // front classification
  rcrs_front #(
    .PLAYERS  (PLAYERS),
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_data)
  );

  // queue between the stages
  rcrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // divider for scale transactions
  rcrs_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // back sequencer and store
  rcrs_back #(
    .PLAYERS  (PLAYERS),
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // no push into a full queue
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  // no pop from an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  // divider started only when free
  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule

[rtl/rcrs_front.sv]
// front stage: accepts and classifies input transactions
module rcrs_front import rcrs_pkg::*; #(
  parameter int PLAYERS  = 8,
  parameter int CHANNELS = 9
) (
  input  logic    clk,
  input  logic    rst_n,
  rcrs_in_if.sink in_ch,
  input  q_stat_t q_stat,
  output logic    q_push,
  output job_t    q_data
);

  logic hold_v_r, hold_v_nxt;
  job_t hold_r, hold_nxt;
  job_t cls;
  logic in_take;

  // classification of the incoming transaction
  always_comb begin
    cls.func          = in_ch.func;
    cls.player_index  = in_ch.player_index;
    cls.channel_index = in_ch.channel_index;
    cls.amount        = in_ch.amount;
    cls.tick_count    = in_ch.tick_count;
    cls.divisor_value = in_ch.divisor_value;
    cls.chan_ok       = ({1'b0, in_ch.channel_index} < 5'(CHANNELS));
    cls.entry_ok      = cls.chan_ok && ({4'b0, in_ch.player_index} < 7'(PLAYERS));
    cls.div_zero      = (in_ch.divisor_value == '0);
    cls.mag           = in_ch.amount[AMOUNT_W-1] ? (~in_ch.amount + 32'd1) : in_ch.amount;
    cls.small_diff    = (cls.mag < SLEW_SMALL);
  end

  // handshake with the queue
  assign in_ch.ready = !hold_v_r || !q_stat.full;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign q_push      = hold_v_r && !q_stat.full;
  assign q_data      = hold_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    if (in_take) begin
      hold_v_nxt = 1'b1;
      hold_nxt   = cls;
    end else if (q_push) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule

[rtl/rcrs_queue.sv]
// short queue of classified transactions between front and back
module rcrs_queue import rcrs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_data,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t            slot_r [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/rcrs_divider.sv]
// radix-2 restoring divider, one quotient bit per cycle
module rcrs_divider import rcrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one trial subtraction per cycle
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

[rtl/rcrs_back.sv]
// back stage: remainder store, sequencer and result register
module rcrs_back import rcrs_pkg::*; #(
  parameter int PLAYERS  = 8,
  parameter int CHANNELS = 9
) (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       q_head,
  input  q_stat_t    q_stat,
  output logic       q_pop,
  output div_req_t   div_req,
  input  div_rsp_t   div_rsp,
  rcrs_out_if.source out_ch
);

  localparam int PL_EFF  = (PLAYERS < PLAYER_SLOTS) ? PLAYERS : PLAYER_SLOTS;
  localparam int ENTRIES = PL_EFF * CHANNELS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_NUM  = 7'b0001000,
    S_GO   = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  job_t                      job_r, job_nxt;
  logic [AW-1:0]             addr_r, addr_nxt;
  logic signed [REM_W-1:0]   rem_eff_r, rem_eff_nxt;
  logic signed [AMOUNT_W-1:0] val_r, val_nxt;
  logic [DEN_W-1:0]          den_r, den_nxt;
  logic signed [NUM_W-1:0]   prod_r, prod_nxt;
  logic signed [NUM_W:0]     num_r, num_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [AMOUNT_W-1:0] res_r, res_nxt;
  logic                      out_v_r, out_v_nxt;
  logic signed [AMOUNT_W-1:0] out_data_r, out_data_nxt;

  // remainder store with a valid bit per entry
  entry_t                    mem [ENTRIES];
  logic [ENTRIES-1:0]        vld_r;
  entry_t                    rdata_r;
  logic                      rd_vld_r;
  logic [AW-1:0]             rd_addr;
  logic                      mem_we;
  entry_t                    mem_wdata;

  entry_t                    ent;
  logic signed [1:0]         amt_sgn;
  logic                      keep_rem;
  logic signed [NUM_W:0]     prod_full;
  logic [NUM_W:0]            num_abs;
  logic                      fast_div;
  logic [NUM_W-1:0]          quo_sel;
  logic [DEN_W-1:0]          rem_sel;
  logic signed [AMOUNT_W-1:0] q_sat;
  logic [AMOUNT_W-1:0]       gmag;
  logic [63:0]               recip_prod;
  logic [AMOUNT_W-1:0]       step_q;
  logic [AMOUNT_W-1:0]       step;
  logic [AMOUNT_W-1:0]       step_gain;
  logic signed [REM_W-1:0]   rem_pos;
  logic signed [REM_W-1:0]   rem_new;

  // store address of the queue head
  assign rd_addr = q_head.entry_ok ?
                   AW'(int'(q_head.player_index) * CHANNELS + int'(q_head.channel_index)) :
                   '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[addr_r] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // entry view, sign and remainder selection
  assign ent      = rd_vld_r ? rdata_r : '0;
  assign amt_sgn  = (job_r.amount == '0) ? SGN_ZERO :
                    (job_r.amount[AMOUNT_W-1] ? SGN_NEG : SGN_POS);
  assign keep_rem = job_r.entry_ok && (ent.sgn == amt_sgn);

  // datapath helpers
  assign prod_full = val_r * $signed({1'b0, job_r.tick_count});
  assign num_abs   = num_r[NUM_W] ? -num_r : num_r;

  // slew divides by eight with a shift, a scale uses the divider
  assign fast_div = (job_r.func == FUNC_SLEW);
  assign quo_sel  = fast_div ? (num_abs[NUM_W-1:0] >> SLEW_DIV_SH) : div_rsp.quo;
  assign rem_sel  = fast_div ? DEN_W'(num_abs[SLEW_DIV_SH-1:0]) : div_rsp.rem;

  // quotient saturation to 32 bits
  always_comb begin
    if (neg_r) begin
      if (quo_sel > 48'h0000_8000_0000) begin
        q_sat = 32'sh8000_0000;
      end else begin
        q_sat = -$signed(quo_sel[AMOUNT_W-1:0]);
      end
    end else begin
      if (quo_sel > 48'h0000_7FFF_FFFF) begin
        q_sat = 32'sh7FFF_FFFF;
      end else begin
        q_sat = $signed(quo_sel[AMOUNT_W-1:0]);
      end
    end
  end

  // slew step: one 29th of the difference by reciprocal multiply, at least one
  assign recip_prod = 64'(job_r.mag) * 64'(SLEW_RECIP);
  assign step_q     = AMOUNT_W'(recip_prod >> SLEW_RECIP_SH);
  assign step       = (step_q == '0) ? 32'd1 : step_q;
  assign step_gain  = step << SLEW_GAIN_SH;

  assign gmag      = q_sat[AMOUNT_W-1] ? (~q_sat + 32'd1) : q_sat;
  assign rem_pos   = $signed({1'b0, rem_sel});
  assign rem_new   = neg_r ? -rem_pos : rem_pos;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    addr_nxt     = addr_r;
    rem_eff_nxt  = rem_eff_r;
    val_nxt      = val_r;
    den_nxt      = den_r;
    prod_nxt     = prod_r;
    num_nxt      = num_r;
    neg_nxt      = neg_r;
    res_nxt      = res_r;
    out_v_nxt    = (out_v_r && out_ch.ready) ? 1'b0 : out_v_r;
    out_data_nxt = out_data_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = '0;
    div_req      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_head;
          addr_nxt  = rd_addr;
          state_nxt = S_LOAD;
        end
      end

      S_LOAD: begin
        rem_eff_nxt = keep_rem ? ent.rem : '0;
        res_nxt     = '0;
        state_nxt   = S_OUT;
        unique case (job_r.func)
          FUNC_SCALE: begin
            if (!job_r.div_zero && job_r.chan_ok) begin
              val_nxt   = job_r.amount;
              den_nxt   = job_r.divisor_value;
              state_nxt = S_MUL;
            end
          end
          FUNC_SLEW: begin
            if (job_r.small_diff) begin
              res_nxt = job_r.amount;
              mem_we  = job_r.entry_ok;
            end else if (job_r.chan_ok) begin
              // signed step with gain, then scaled over ticks and divided by eight with a shift
              val_nxt   = job_r.amount[AMOUNT_W-1] ? -$signed(step_gain) : $signed(step_gain);
              state_nxt = S_MUL;
            end
          end
          FUNC_CLEAR: begin
            mem_we = job_r.entry_ok;
          end
          FUNC_NONE: begin
            res_nxt = '0;
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end

      S_MUL: begin
        prod_nxt  = prod_full[NUM_W-1:0];
        state_nxt = S_NUM;
      end

      S_NUM: begin
        num_nxt   = {prod_r[NUM_W-1], prod_r} + (NUM_W + 1)'(rem_eff_r);
        state_nxt = S_GO;
      end

      S_GO: begin
        neg_nxt = num_r[NUM_W];
        if (!fast_div) begin
          div_req.start = 1'b1;
          div_req.num   = num_abs[NUM_W-1:0];
          div_req.den   = den_r;
        end
        state_nxt = S_DIV;
      end

      S_DIV: begin
        if (fast_div || div_rsp.done) begin
          state_nxt = S_OUT;
          if (fast_div && gmag >= job_r.mag) begin
            // overshoot: answer the difference and clear the entry
            res_nxt = job_r.amount;
            mem_we  = job_r.entry_ok;
          end else begin
            res_nxt       = q_sat;
            mem_we        = job_r.entry_ok;
            mem_wdata.rem = rem_new;
            mem_wdata.sgn = amt_sgn;
          end
        end
      end

      S_OUT: begin
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt    = 1'b1;
          out_data_nxt = res_r;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
    job_r      <= job_nxt;
    addr_r     <= addr_nxt;
    rem_eff_r  <= rem_eff_nxt;
    val_r      <= val_nxt;
    den_r      <= den_nxt;
    prod_r     <= prod_nxt;
    num_r      <= num_nxt;
    neg_r      <= neg_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.scaled_out = out_data_r;

endmodule
